// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the deque rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define BDEQ_ASSERT(name, clk_sig, rst_sig, prop) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("bdeq assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define BDEQ_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("bdeq assertion failed");

`else

`define BDEQ_ASSERT(name, clk_sig, rst_sig, prop)
`define BDEQ_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons)

`endif

`endif

// ===== rtl/bdeq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdeq_pkg
// Types and constants of the bounded double-ended queue
// ---------------------------------------------------------------------------
package bdeq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 11;
    localparam int CMD_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic publish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/bdeq_ram.sv =====
// ---------------------------------------------------------------------------
// bdeq_ram
// Generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bdeq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: capture a command, execute it, load the result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdeq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bdeq_pkg::dp_status_t   sts,
    output bdeq_pkg::ctrl_cmd_t    ctl
);

    bdeq_pkg::state_t state_reg;
    bdeq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdeq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctl.capture = 1'b0;
        ctl.exec    = 1'b0;
        ctl.publish = 1'b0;
        unique case (state_reg)
            bdeq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = bdeq_pkg::ST_EXEC;
                end
            end
            bdeq_pkg::ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = bdeq_pkg::ST_LOAD;
            end
            bdeq_pkg::ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    ctl.publish = 1'b1;
                    state_next  = bdeq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdeq_pkg::ST_IDLE;
            end
        endcase
    end

    `BDEQ_ASSERT_NEXT(a_exec_then_load, clk, rst_n,
        state_reg == bdeq_pkg::ST_EXEC, state_reg == bdeq_pkg::ST_LOAD)
    `BDEQ_ASSERT_NEXT(a_load_waits_for_slot, clk, rst_n,
        state_reg == bdeq_pkg::ST_LOAD && !sts.out_free, state_reg == bdeq_pkg::ST_LOAD)

endmodule

// ===== rtl/bdeq_dp.sv =====
// ---------------------------------------------------------------------------
// bdeq_dp
// Ring buffer pointers, entry ram, end-value registers and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdeq_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bdeq_pkg::ctrl_cmd_t               ctl,
    output bdeq_pkg::dp_status_t              sts,
    input  logic                              cfg_valid,
    input  logic [bdeq_pkg::CAP_W-1:0]        cfg_data,
    input  logic [bdeq_pkg::CMD_W-1:0]        command,
    input  logic signed [bdeq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [bdeq_pkg::DATA_W-1:0] front_value,
    output logic signed [bdeq_pkg::DATA_W-1:0] rear_value,
    output logic                              is_empty,
    output logic                              is_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > bdeq_pkg::CAP_W) ? CNT_W : bdeq_pkg::CAP_W;
    localparam int DW    = bdeq_pkg::DATA_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    logic [bdeq_pkg::CAP_W-1:0]  cap_reg;
    logic [PTR_W-1:0]            front_ptr_reg, front_ptr_next;
    logic [PTR_W-1:0]            rear_ptr_reg, rear_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [bdeq_pkg::CMD_W-1:0]  cmd_reg;
    logic [DW-1:0]               word_reg;
    logic                        ok_reg, ok_next;
    logic [DW-1:0]               front_val_reg, front_val_next;
    logic [DW-1:0]               rear_val_reg, rear_val_next;
    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic [DW-1:0]               out_front_reg, out_rear_reg;
    logic                        out_empty_reg, out_full_reg;

    logic [CMP_W-1:0]            cap_ext, eff_cap;
    logic                        full_now, empty_now;

    logic                        ram_we, ram_re;
    logic [PTR_W-1:0]            ram_waddr, ram_raddr;
    logic [DW-1:0]               ram_rdata;

    assign cap_ext   = CMP_W'(cap_reg);
    assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign full_now  = CMP_W'(count_reg) >= eff_cap;
    assign empty_now = (count_reg == '0);

    // execute: pointer update, ram write for a push, ram read of the new end for a pop
    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        rear_ptr_next  = rear_ptr_reg;
        count_next     = count_reg;
        ok_next        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = rear_ptr_reg;
        ram_re         = 1'b0;
        ram_raddr      = ring_next(front_ptr_reg);
        unique case (cmd_reg)
            bdeq_pkg::CMD_PUSH_FRONT:
            begin
                if (!full_now)
                begin
                    ok_next        = 1'b1;
                    front_ptr_next = ring_prev(front_ptr_reg);
                    ram_we         = ctl.exec;
                    ram_waddr      = ring_prev(front_ptr_reg);
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            bdeq_pkg::CMD_PUSH_REAR:
            begin
                if (!full_now)
                begin
                    ok_next       = 1'b1;
                    ram_we        = ctl.exec;
                    ram_waddr     = rear_ptr_reg;
                    rear_ptr_next = ring_next(rear_ptr_reg);
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            bdeq_pkg::CMD_POP_FRONT:
            begin
                if (!empty_now)
                begin
                    ok_next        = 1'b1;
                    front_ptr_next = ring_next(front_ptr_reg);
                    ram_re         = ctl.exec;
                    ram_raddr      = ring_next(front_ptr_reg);
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            bdeq_pkg::CMD_POP_REAR:
            begin
                if (!empty_now)
                begin
                    ok_next       = 1'b1;
                    rear_ptr_next = ring_prev(rear_ptr_reg);
                    ram_re        = ctl.exec;
                    ram_raddr     = ring_prev(ring_prev(rear_ptr_reg));
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            bdeq_pkg::CMD_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // end values after the transaction; count_reg already holds the new count
    always_comb
    begin
        front_val_next = front_val_reg;
        rear_val_next  = rear_val_reg;
        if (ok_reg)
        begin
            unique case (cmd_reg)
                bdeq_pkg::CMD_PUSH_FRONT:
                begin
                    front_val_next = word_reg;
                    if (count_reg == CNT_W'(1))
                    begin
                        rear_val_next = word_reg;
                    end
                end
                bdeq_pkg::CMD_PUSH_REAR:
                begin
                    rear_val_next = word_reg;
                    if (count_reg == CNT_W'(1))
                    begin
                        front_val_next = word_reg;
                    end
                end
                bdeq_pkg::CMD_POP_FRONT:
                begin
                    front_val_next = ram_rdata;
                end
                bdeq_pkg::CMD_POP_REAR:
                begin
                    rear_val_next = ram_rdata;
                end
                default:
                begin
                    front_val_next = front_val_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bdeq_pkg::CAP_RESET;
            front_ptr_reg <= '0;
            rear_ptr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (ctl.exec)
            begin
                front_ptr_reg <= front_ptr_next;
                rear_ptr_reg  <= rear_ptr_next;
                count_reg     <= count_next;
            end
            if (ctl.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= command;
            word_reg <= value;
        end
        if (ctl.exec)
        begin
            ok_reg <= ok_next;
        end
        if (ctl.publish)
        begin
            front_val_reg <= front_val_next;
            rear_val_reg  <= rear_val_next;
            out_ok_reg    <= ok_reg;
            out_front_reg <= empty_now ? '1 : front_val_next;
            out_rear_reg  <= empty_now ? '1 : rear_val_next;
            out_empty_reg <= empty_now;
            out_full_reg  <= full_now;
        end
    end

    bdeq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign front_value  = out_front_reg;
    assign rear_value   = out_rear_reg;
    assign is_empty     = out_empty_reg;
    assign is_full      = out_full_reg;

    `BDEQ_ASSERT(a_count_in_range, clk, rst_n, CMP_W'(count_reg) <= DEPTH_C)
    `BDEQ_ASSERT(a_empty_reads_minus_one, clk, rst_n,
        !(out_valid_reg && out_empty_reg) || (out_front_reg == '1 && out_rear_reg == '1))
    `BDEQ_ASSERT_NEXT(a_publish_fills_slot, clk, rst_n, ctl.publish, out_valid_reg)

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit words held in a ring buffer
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   push front, push rear, pop front, pop rear or query, with the word to push.
//   Output channel (out_valid/out_ready) returns one result per command: ok,
//   the front and rear words after the command (-1 when empty), is_empty and
//   is_full.
//   Config channel (cfg_valid/cfg_ready) writes the capacity; cfg_ready is
//   always high. Write it only while no command is in flight.
//   The sequencer steps through capture, execute (at most one ram write or ram read)
//   and result load, which makes the result valid; it accepts no new command
//   until the result is loaded into the output register.
//   A new command is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the next result is held back
//   until the output register empties, and input stays blocked meanwhile.
//   Reset empties the queue and sets the capacity to 1024.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bdeq_pkg::CMD_W-1:0]         command,
    input  logic signed [bdeq_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               ok,
    output logic signed [bdeq_pkg::DATA_W-1:0] front_value,
    output logic signed [bdeq_pkg::DATA_W-1:0] rear_value,
    output logic                               is_empty,
    output logic                               is_full,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdeq_pkg::CAP_W-1:0]         cfg_data
);

    bdeq_pkg::ctrl_cmd_t  ctl;
    bdeq_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    bdeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

// ===== dv/bounded_double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_double_ended_queue_tb
// Drives push, pop, query and reserved commands into the bounded deque under several
// capacity settings and checks every result against a ring buffer model
// kept in the testbench. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RING_DEPTH   = 1024;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;
    localparam int FILL_ITEMS   = 40;
    localparam int PHASE_ITEMS  = 75;
    localparam int NUM_PHASES   = 8;

    localparam logic [bdeq_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [bdeq_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [bdeq_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic [bdeq_pkg::DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [bdeq_pkg::DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [bdeq_pkg::DATA_W-1:0] WORD_NEG1 = 32'hffff_ffff;

    typedef struct {
        logic                               ok;
        logic signed [bdeq_pkg::DATA_W-1:0] front_w;
        logic signed [bdeq_pkg::DATA_W-1:0] rear_w;
        logic                               empty;
        logic                               full;
    } deque_result_t;

    class deque_tracker;
        logic [bdeq_pkg::DATA_W-1:0] ring [RING_DEPTH];
        int unsigned                 head;
        int unsigned                 tail;
        int unsigned                 count;
        logic [bdeq_pkg::CAP_W-1:0]  cap;
        deque_result_t               expected_results [$];
        int unsigned                 mismatches;

        function new();
            head       = 0;
            tail       = 0;
            count      = 0;
            cap        = bdeq_pkg::CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [bdeq_pkg::CAP_W-1:0] value);
            cap = value;
        endfunction

        function bit at_limit();
            return count >= ((cap > RING_DEPTH) ? RING_DEPTH : int'(cap));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        // apply one accepted command and queue the result it must produce
        function void apply_command(logic [bdeq_pkg::CMD_W-1:0] cmd,
                                    logic [bdeq_pkg::DATA_W-1:0] word);
            deque_result_t r;
            r.ok = 1'b1;
            case (cmd)
                bdeq_pkg::CMD_PUSH_FRONT:
                    if (at_limit())
                        r.ok = 1'b0;
                    else
                    begin
                        head = (head == 0) ? RING_DEPTH - 1 : head - 1;
                        ring[head] = word;
                        count++;
                    end
                bdeq_pkg::CMD_PUSH_REAR:
                    if (at_limit())
                        r.ok = 1'b0;
                    else
                    begin
                        ring[tail] = word;
                        tail = (tail == RING_DEPTH - 1) ? 0 : tail + 1;
                        count++;
                    end
                bdeq_pkg::CMD_POP_FRONT:
                    if (count == 0)
                        r.ok = 1'b0;
                    else
                    begin
                        head = (head == RING_DEPTH - 1) ? 0 : head + 1;
                        count--;
                    end
                bdeq_pkg::CMD_POP_REAR:
                    if (count == 0)
                        r.ok = 1'b0;
                    else
                    begin
                        tail = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
                        count--;
                    end
                bdeq_pkg::CMD_QUERY: ;
                default: r.ok = 1'b0;
            endcase
            if (count != 0)
            begin
                r.front_w = ring[head];
                r.rear_w  = ring[(tail == 0) ? RING_DEPTH - 1 : tail - 1];
            end
            else
            begin
                r.front_w = WORD_NEG1;
                r.rear_w  = WORD_NEG1;
            end
            r.empty = (count == 0);
            r.full  = at_limit();
            expected_results.push_back(r);
        endfunction

        function void check_response(logic ok_a, logic signed [bdeq_pkg::DATA_W-1:0] front_a,
                                     logic signed [bdeq_pkg::DATA_W-1:0] rear_a,
                                     logic empty_a, logic full_a);
            deque_result_t r;
            if (expected_results.size() == 0)
            begin
                note_error("result transaction with no command outstanding");
                return;
            end
            r = expected_results.pop_front();
            if (r.ok !== ok_a || r.front_w !== front_a || r.rear_w !== rear_a ||
                r.empty !== empty_a || r.full !== full_a)
                note_error($sformatf({"mismatch: exp ok=%0b front=%0d rear=%0d ",
                                      "empty=%0b full=%0b, got ok=%0b front=%0d ",
                                      "rear=%0d empty=%0b full=%0b"},
                                     r.ok, r.front_w, r.rear_w, r.empty, r.full,
                                     ok_a, front_a, rear_a, empty_a, full_a));
        endfunction
    endclass

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic [bdeq_pkg::CMD_W-1:0]          command   = '0;
    logic signed [bdeq_pkg::DATA_W-1:0]  value     = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b1;
    logic                                ok;
    logic signed [bdeq_pkg::DATA_W-1:0]  front_value;
    logic signed [bdeq_pkg::DATA_W-1:0]  rear_value;
    logic                                is_empty;
    logic                                is_full;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [bdeq_pkg::CAP_W-1:0]          cfg_data  = '0;

    deque_tracker tracker = new();
    bit           gaps_on = 1'b1;
    int unsigned  stall_cycles = 0;

    bounded_double_ended_queue #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_capacity(cfg_data);
            if (in_valid && in_ready)
                tracker.apply_command(command, value);
            if (out_valid && out_ready)
                tracker.check_response(ok, front_value, rear_value, is_empty, is_full);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
                (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(input logic [bdeq_pkg::CMD_W-1:0] cmd,
                            input logic [bdeq_pkg::DATA_W-1:0] word);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= word;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [bdeq_pkg::CAP_W-1:0] cap_value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap_value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [bdeq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return WORD_NEG1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bdeq_pkg::CMD_W-1:0] pick_command(int push_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_weight)
            return ($urandom_range(0, 1) == 0) ? bdeq_pkg::CMD_PUSH_FRONT
                                               : bdeq_pkg::CMD_PUSH_REAR;
        if (roll < 92)
            return ($urandom_range(0, 1) == 0) ? bdeq_pkg::CMD_POP_FRONT
                                               : bdeq_pkg::CMD_POP_REAR;
        if (roll < 96)
            return bdeq_pkg::CMD_QUERY;
        case ($urandom_range(0, 2))
            0: return CMD_RSVD_5;
            1: return CMD_RSVD_6;
            default: return CMD_RSVD_7;
        endcase
    endfunction

    initial
    begin
        logic [bdeq_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];
        int                         push_weight;

        phase_caps = '{11'd1, 11'd2, 11'd0, 11'd7, 11'd33, 11'd2047, bdeq_pkg::CAP_RESET,
                       11'($urandom_range(1, 2047))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue, field extremes, reserved codes
        send_cmd(bdeq_pkg::CMD_QUERY, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_PUSH_FRONT, WORD_MIN);
        send_cmd(bdeq_pkg::CMD_PUSH_REAR, WORD_MAX);
        send_cmd(bdeq_pkg::CMD_PUSH_FRONT, WORD_NEG1);
        send_cmd(bdeq_pkg::CMD_PUSH_REAR, '0);
        send_cmd(bdeq_pkg::CMD_QUERY, WORD_MAX);
        send_cmd(CMD_RSVD_5, $urandom);
        send_cmd(CMD_RSVD_6, $urandom);
        send_cmd(CMD_RSVD_7, $urandom);
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());

        // zero capacity: full and empty at once
        write_capacity(11'd0);
        send_cmd(bdeq_pkg::CMD_PUSH_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_PUSH_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());

        // capacity lowered below the count
        write_capacity(11'd3);
        repeat (3) send_cmd(bdeq_pkg::CMD_PUSH_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_PUSH_FRONT, pick_word());
        write_capacity(11'd1);
        send_cmd(bdeq_pkg::CMD_PUSH_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());

        // fill to the capacity and empty again
        write_capacity(11'(FILL_ITEMS));
        repeat (FILL_ITEMS) send_cmd(bdeq_pkg::CMD_PUSH_REAR, pick_word());
        send_cmd(bdeq_pkg::CMD_PUSH_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_PUSH_REAR, pick_word());
        repeat (FILL_ITEMS) send_cmd(bdeq_pkg::CMD_POP_FRONT, pick_word());
        send_cmd(bdeq_pkg::CMD_POP_REAR, pick_word());

        // random phases over several capacities
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            gaps_on = (p != 2) && (p != NUM_PHASES - 1);
            push_weight = (p % 2 == 0) ? 60 : 35;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    push_weight = 100 - push_weight;
                send_cmd(pick_command(push_weight), pick_word());
                if (gaps_on && $urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
